// File: hdl/x86ild_pkg.sv
`default_nettype none

package x86ild_pkg;

  // Longest legal instruction; anything longer is flagged
  localparam int unsigned MAX_LEN = 15;

  // Walk phases
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_REX    = 3'd1;
  localparam logic [2:0] PH_ESC    = 3'd2;
  localparam logic [2:0] PH_ESC2   = 3'd3;
  localparam logic [2:0] PH_OPC    = 3'd4;
  localparam logic [2:0] PH_MODRM  = 3'd5;
  localparam logic [2:0] PH_SIB    = 3'd6;
  localparam logic [2:0] PH_SKIP   = 3'd7;

  // Opcode maps
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_0F   = 2'd1;
  localparam logic [1:0] ESC_0F38 = 2'd2;
  localparam logic [1:0] ESC_0F3A = 2'd3;

  // Config register indexes
  localparam logic REG_LONG_MODE = 1'b0;

  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] byte_count;
    logic [3:0] skip_left;
    logic [3:0] opsize_any;
    logic [2:0] opsize_nopromote;
    logic       fpu;
    logic       op16;
    logic       rexw;
    logic       modrm_seen;
    logic       sib_seen;
    logic [1:0] escape;
    logic [7:0] opcode;
    logic [7:0] modrm;
    logic [7:0] sib;
  } x86ild_state_t;

  localparam x86ild_state_t STATE_INIT = '{
    phase:            PH_PREFIX,
    byte_count:       5'd0,
    skip_left:        4'd0,
    opsize_any:       4'd4,
    opsize_nopromote: 3'd4,
    fpu:              1'b0,
    op16:             1'b0,
    rexw:             1'b0,
    modrm_seen:       1'b0,
    sib_seen:         1'b0,
    escape:           ESC_NONE,
    opcode:           8'd0,
    modrm:            8'd0,
    sib:              8'd0
  };

  typedef struct packed {
    logic [4:0] length;
    logic       overlong;
    logic       is_fpu;
    logic       op16_prefix;
    logic       rex_w;
    logic [1:0] escape_kind;
    logic [7:0] opcode_byte;
    logic       modrm_present;
    logic [7:0] modrm_byte;
    logic       has_sib;
    logic [7:0] sib_byte;
  } x86ild_result_t;

  // Prefix set, including the 62/63/E2/E3 pattern
  function automatic logic is_prefix(input logic [7:0] b);
    return (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3) || (b[7:2] == 6'b011001) ||
           (b[7:3] == 5'b11011) || (b[6:1] == 6'b110001);
  endfunction

  // One-byte map: opcode takes a ModRM byte
  function automatic logic modrm_one(input logic [7:0] op);
    logic r;
    unique case (op)
      8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC4, 8'hC5,
      8'hC6, 8'hC7, 8'hF6, 8'hF7, 8'hFE, 8'hFF: r = 1'b1;
      default: r = ((op & 8'hC4) == 8'h00) || (op[7:4] == 4'h8) ||
                   (op[7:2] == 6'b110100) || ((op & 8'hF6) == 8'hF6);
    endcase
    return r;
  endfunction

  // 0F map: opcode takes a ModRM byte
  function automatic logic modrm_two(input logic [7:0] op);
    logic r;
    unique case (op)
      8'h06, 8'h08, 8'h09, 8'h0B, 8'h0D, 8'h19, 8'h1A, 8'h1B,
      8'h1C, 8'h1D, 8'h1E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h37, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA: r = 1'b0;
      default: r = !((op[7:3] == 5'b11001) || (op[7:4] == 4'h8));
    endcase
    return r;
  endfunction

  // Immediate size in bytes
  function automatic logic [3:0] imm_len(input x86ild_state_t s);
    logic [3:0] r;
    logic       reg_zero;
    reg_zero = (s.modrm[5:4] == 2'b00);
    r = 4'd0;
    if (!s.fpu) begin
      unique case (s.escape)
        ESC_NONE: begin
          unique case (s.opcode)
            8'h04, 8'h0C, 8'h14, 8'h1C, 8'h24, 8'h2C, 8'h34, 8'h3C,
            8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hB0, 8'hB1,
            8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hC0, 8'hC1,
            8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hE4, 8'hE5, 8'hE6, 8'hE7,
            8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
            8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F,
            8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hEB, 8'hA0, 8'hA2: r = 4'd1;
            8'hF6: r = reg_zero ? 4'd1 : 4'd0;
            8'hC2, 8'hCA: r = 4'd2;
            8'h05, 8'h0D, 8'h15, 8'h1D, 8'h25, 8'h2D, 8'h35, 8'h3D,
            8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9:
              r = {1'b0, s.opsize_nopromote};
            8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF,
            8'hA1, 8'hA3: r = s.opsize_any;
            8'hF7: r = reg_zero ? {1'b0, s.opsize_nopromote} : 4'd0;
            default: r = 4'd0;
          endcase
        end
        ESC_0F: begin
          unique case (s.opcode)
            8'h0F, 8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA,
            8'hC2, 8'hC4, 8'hC5, 8'hC6: r = 4'd1;
            default: r = (s.opcode[7:4] == 4'h8) ? {1'b0, s.opsize_nopromote} : 4'd0;
          endcase
        end
        ESC_0F3A: begin
          unique case (s.opcode)
            8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h14,
            8'h15, 8'h16, 8'h17, 8'h20, 8'h21, 8'h22, 8'h42, 8'h62,
            8'h63: r = 4'd1;
            default: r = 4'd0;
          endcase
        end
        ESC_0F38: r = 4'd0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/x86_instruction_length_decoder_unit.sv
// x86 instruction length decoder.
// Input stream: one code byte per beat on s_axis_tdata, with s_axis_tuser set
// to force that byte to begin a new instruction (a partial one is dropped).
// Output stream: one beat per completed instruction on m_axis_tdata carrying
// the length (saturating at 31), overlong flag and the decoded prefix, map,
// opcode, ModRM and SIB fields. Bytes that do not end an instruction give no
// output beat.
// Path: an accepted input beat goes into the input register, then one decode
// pass writes its result into the output register.
// Throughput: one byte per cycle while the output is not stalled; the per-byte
// decode state update is the single loop.
// Config: APB register 0 (long_mode, reset 1) selects REX decoding; write it
// only while the stream is idle.
// Reset: synchronous rst clears the pipeline, returns the walker to the
// prefix phase and sets long_mode.
// Stall: while m_axis_tready is low the finished result holds in the output
// register and the input register keeps one byte; s_axis_tready drops only
// when both are full.
`default_nettype none

module x86_instruction_length_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] code_byte
  input  wire logic        s_axis_tuser,  // [0] start_new
  // Instruction stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // [4:0] length, [5] overlong, [6] is_fpu,
                                          // [7] op16_prefix, [8] rex_w,
                                          // [10:9] escape_kind, [18:11] opcode_byte,
                                          // [19] modrm_present, [27:20] modrm_byte,
                                          // [28] has_sib, [36:29] sib_byte, [39:37] 0
);
  import x86ild_pkg::*;

  logic           long_mode;
  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_start;
  x86ild_state_t  state;
  x86ild_state_t  state_next;
  logic           emit;
  x86ild_result_t result;
  logic           out_free;
  logic           advance;

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LONG_MODE) ? {31'd0, long_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LONG_MODE) begin
      long_mode <= pwdata[0];
    end
  end

  // Handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  // Decode pass
  x86ild_step u_step (
    .cur       (state),
    .code_byte (in_byte),
    .start_new (in_start),
    .long_mode (long_mode),
    .nxt       (state_next),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_INIT;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_axis_tdata <= {3'd0, result.sib_byte, result.has_sib, result.modrm_byte,
                       result.modrm_present, result.opcode_byte, result.escape_kind,
                       result.rex_w, result.op16_prefix, result.is_fpu,
                       result.overlong, result.length};
    end
  end

endmodule

`default_nettype wire

// File: hdl/x86ild_step.sv
`default_nettype none

module x86ild_step (
  input  wire x86ild_pkg::x86ild_state_t  cur,
  input  wire logic [7:0]                 code_byte,
  input  wire logic                       start_new,
  input  wire logic                       long_mode,
  output x86ild_pkg::x86ild_state_t       nxt,
  output logic                            emit,
  output x86ild_pkg::x86ild_result_t      result
);
  import x86ild_pkg::*;

  x86ild_state_t s;
  logic          handled;
  logic          take;
  logic          after;
  logic          tail_en;
  logic          fin;
  logic [3:0]    disp;
  logic [3:0]    skip_sum;
  logic [1:0]    mod;
  logic [2:0]    rm;

  always_comb begin
    s        = cur;
    handled  = 1'b0;
    take     = 1'b0;
    after    = 1'b0;
    tail_en  = 1'b0;
    fin      = 1'b0;
    disp     = 4'd0;
    skip_sum = 4'd0;
    mod      = 2'd0;
    rm       = 3'd0;
    result   = '0;

    // Restart on request, count the byte
    if (start_new) s = STATE_INIT;
    if (s.byte_count != 5'd31) s.byte_count = s.byte_count + 5'd1;

    // Prefix bytes
    if (s.phase == PH_PREFIX) begin
      if (is_prefix(code_byte)) begin
        handled = 1'b1;
        if (code_byte == 8'h66) begin
          s.op16             = 1'b1;
          s.opsize_any       = 4'd2;
          s.opsize_nopromote = 3'd2;
        end else if (code_byte[7:3] == 5'b11011) begin
          s.fpu   = 1'b1;
          s.phase = PH_REX;
        end
      end else begin
        s.phase = PH_REX;
      end
    end

    // REX bytes in long mode
    if (!handled && s.phase == PH_REX) begin
      if (long_mode && code_byte[7:4] == 4'h4) begin
        handled = 1'b1;
        if (code_byte[3]) begin
          s.rexw       = 1'b1;
          s.opsize_any = 4'd8;
        end
      end else begin
        s.phase = PH_ESC;
      end
    end

    // Escapes, opcode, ModRM, SIB, trailing bytes
    if (!handled) begin
      unique case (s.phase)
        PH_ESC: begin
          if (code_byte == 8'h0F) begin
            s.escape = ESC_0F;
            s.phase  = PH_ESC2;
          end else begin
            take = 1'b1;
          end
        end
        PH_ESC2: begin
          if (code_byte == 8'h38 || code_byte == 8'h3A) begin
            s.escape = (code_byte == 8'h38) ? ESC_0F38 : ESC_0F3A;
            s.phase  = PH_OPC;
          end else begin
            take = 1'b1;
          end
        end
        PH_OPC: take = 1'b1;
        PH_MODRM: begin
          s.modrm = code_byte;
          after   = 1'b1;
        end
        PH_SIB: begin
          s.sib = code_byte;
          if (s.modrm[7:6] == 2'd0 && code_byte[2:0] == 3'd5) disp = 4'd4;
          if (s.modrm[7:6] == 2'd1) disp = disp + 4'd1;
          if (s.modrm[7:6] == 2'd2) disp = disp + 4'd4;
          tail_en = 1'b1;
        end
        PH_SKIP: begin
          if (s.skip_left != 4'd0) s.skip_left = s.skip_left - 4'd1;
          if (s.skip_left == 4'd0) fin = 1'b1;
        end
        PH_PREFIX, PH_REX: begin
        end
      endcase
    end

    // Opcode byte
    if (take) begin
      s.opcode = code_byte;
      if (s.fpu) begin
        if (code_byte[7:6] != 2'b11) begin
          s.modrm_seen = 1'b1;
          s.modrm      = code_byte;
          after        = 1'b1;
        end else begin
          tail_en = 1'b1;
        end
      end else if ((s.escape == ESC_NONE && modrm_one(code_byte)) ||
                   (s.escape == ESC_0F && modrm_two(code_byte)) ||
                   s.escape == ESC_0F38 || s.escape == ESC_0F3A) begin
        s.modrm_seen = 1'b1;
        s.phase      = PH_MODRM;
      end else begin
        tail_en = 1'b1;
      end
    end

    // Addressing form from ModRM
    if (after) begin
      mod = s.modrm[7:6];
      rm  = s.modrm[2:0];
      if (mod != 2'd3 && rm == 3'd4) begin
        s.sib_seen = 1'b1;
        s.phase    = PH_SIB;
      end else begin
        tail_en = 1'b1;
        if (mod == 2'd0 && rm == 3'd5) disp = 4'd4;
        else if (mod == 2'd1)          disp = 4'd1;
        else if (mod == 2'd2)          disp = 4'd4;
        else                           disp = 4'd0;
      end
    end

    // Displacement plus immediate still to come
    if (tail_en) begin
      skip_sum    = disp + imm_len(s);
      s.skip_left = skip_sum;
      if (skip_sum == 4'd0) fin = 1'b1;
      else s.phase = PH_SKIP;
    end

    // Instruction complete
    if (fin) begin
      result.length        = s.byte_count;
      result.overlong      = (s.byte_count > 5'(MAX_LEN));
      result.is_fpu        = s.fpu;
      result.op16_prefix   = s.op16;
      result.rex_w         = s.rexw;
      result.escape_kind   = s.escape;
      result.opcode_byte   = s.opcode;
      result.modrm_present = s.modrm_seen;
      result.modrm_byte    = s.modrm_seen ? s.modrm : 8'd0;
      result.has_sib       = s.sib_seen;
      result.sib_byte      = s.sib_seen ? s.sib : 8'd0;
      s = STATE_INIT;
    end

    nxt  = s;
    emit = fin;
  end

endmodule

`default_nettype wire
